### rtl/core/aff_inv_pkg.sv
// ----------------------------------------------------------------------------
// aff_inv_pkg
// shared types and helpers for the affine 2x3 inverse pipeline
// ----------------------------------------------------------------------------
package aff_inv_pkg;

	localparam int NUM_LANES = 6;   // six inverse entries, one divider lane each
	localparam int QW        = 32;  // quotient width
	localparam int DW        = 64;  // determinant / remainder width
	localparam int NUM_STEPS = QW;  // one quotient bit per divider stage

	// lane order follows the output entries
	localparam int LANE_A = 0;
	localparam int LANE_B = 1;
	localparam int LANE_C = 2;
	localparam int LANE_D = 3;
	localparam int LANE_E = 4;
	localparam int LANE_F = 5;

	localparam logic [QW-1:0] POS_LIMIT = 32'h7FFF_FFFF;
	localparam logic [QW-1:0] NEG_LIMIT = 32'h8000_0000;

	typedef struct packed {
		logic valid;
		logic singular;
	} ctl_t;

	// rem: partial remainder, lq: low dividend bits shifting out, quotient bits in
	typedef struct packed {
		logic [DW-1:0] rem;
		logic [QW-1:0] lq;
		logic          neg;
		logic          ovf;
	} lane_t;

	function automatic logic [31:0] mag32(input logic [31:0] v);
		return v[31] ? (~v + 32'd1) : v;
	endfunction

endpackage

### rtl/core/aff_front.sv
// ----------------------------------------------------------------------------
// aff_front
// products, determinant and numerators, then divider operand setup
// ----------------------------------------------------------------------------
module aff_front
	import aff_inv_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic signed [31:0]          in_a,
	input  logic signed [31:0]          in_b,
	input  logic signed [31:0]          in_c,
	input  logic signed [31:0]          in_d,
	input  logic signed [31:0]          in_e,
	input  logic signed [31:0]          in_f,
	output ctl_t                        ctl_s3,
	output logic [DW-1:0]               dm_s3,
	output lane_t [NUM_LANES-1:0]       lanes_s3
);

	// stage 1: six products
	logic              valid_s1;
	logic signed [63:0] p_ad_s1, p_bc_s1, p_cf_s1, p_de_s1, p_be_s1, p_af_s1;
	logic [31:0]       a_s1, b_s1, c_s1, d_s1;
	// stage 2: differences, 64-bit wrapping
	logic              valid_s2;
	logic [63:0]       det_s2, ne_s2, nf_s2;
	logic [31:0]       a_s2, b_s2, c_s2, d_s2;
	// stage 3 next values
	logic              det_neg;
	logic [DW-1:0]     det_mag;
	logic [31:0]       ent_mag [4];
	logic              ent_neg [4];
	logic [63:0]       wn [2];
	logic [63:0]       wm;
	lane_t [NUM_LANES-1:0] lanes_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			ctl_s3   <= '0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			ctl_s3.valid    <= valid_s2;
			ctl_s3.singular <= (det_s2 == 64'd0);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_ad_s1 <= in_a * in_d;
			p_bc_s1 <= in_b * in_c;
			p_cf_s1 <= in_c * in_f;
			p_de_s1 <= in_d * in_e;
			p_be_s1 <= in_b * in_e;
			p_af_s1 <= in_a * in_f;
			a_s1 <= in_a;
			b_s1 <= in_b;
			c_s1 <= in_c;
			d_s1 <= in_d;
			det_s2 <= 64'(p_ad_s1 - p_bc_s1);
			ne_s2  <= 64'(p_cf_s1 - p_de_s1);
			nf_s2  <= 64'(p_be_s1 - p_af_s1);
			a_s2 <= a_s1;
			b_s2 <= b_s1;
			c_s2 <= c_s1;
			d_s2 <= d_s1;
			dm_s3    <= det_mag;
			lanes_s3 <= lanes_n;
		end
	end

	always_comb begin
		det_neg = det_s2[63];
		det_mag = det_neg ? (~det_s2 + 64'd1) : det_s2;
		// single-value numerators: d, -b, -c, a
		ent_mag[0] = mag32(d_s2);
		ent_neg[0] = d_s2[31];
		ent_mag[1] = mag32(b_s2);
		ent_neg[1] = !b_s2[31] && (b_s2 != 32'd0);
		ent_mag[2] = mag32(c_s2);
		ent_neg[2] = !c_s2[31] && (c_s2 != 32'd0);
		ent_mag[3] = mag32(a_s2);
		ent_neg[3] = a_s2[31];
		wn[0] = ne_s2;
		wn[1] = nf_s2;
		wm = '0;
		lanes_n = '0;
		// numerator is mag << 32: top half seeds the remainder
		for (int i = 0; i < 4; i++) begin
			lanes_n[i].rem = {32'd0, ent_mag[i]};
			lanes_n[i].lq  = '0;
			lanes_n[i].neg = ent_neg[i] ^ det_neg;
			lanes_n[i].ovf = ({32'd0, ent_mag[i]} >= det_mag);
		end
		// product-difference numerators are scaled by 2^16
		for (int j = 0; j < 2; j++) begin
			wm = wn[j][63] ? (~wn[j] + 64'd1) : wn[j];
			lanes_n[LANE_E + j].rem = {16'd0, wm[63:16]};
			lanes_n[LANE_E + j].lq  = {wm[15:0], 16'd0};
			lanes_n[LANE_E + j].neg = wn[j][63] ^ det_neg;
			lanes_n[LANE_E + j].ovf = ({16'd0, wm} >= {det_mag, 16'd0});
		end
	end

endmodule

### rtl/core/aff_div_step.sv
// ----------------------------------------------------------------------------
// aff_div_step
// one restoring-division stage: one quotient bit for each of the six lanes
// ----------------------------------------------------------------------------
module aff_div_step
	import aff_inv_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  ctl_t                  ctl_in,
	input  logic [DW-1:0]         dm_in,
	input  lane_t [NUM_LANES-1:0] lanes_in,
	output ctl_t                  ctl_s1,
	output logic [DW-1:0]         dm_s1,
	output lane_t [NUM_LANES-1:0] lanes_s1
);

	lane_t [NUM_LANES-1:0] lanes_n;
	logic [DW:0]           trial;
	logic                  ge;

	always_comb begin
		lanes_n = lanes_in;
		trial = '0;
		ge = 1'b0;
		for (int i = 0; i < NUM_LANES; i++) begin
			trial = {lanes_in[i].rem, lanes_in[i].lq[QW-1]};
			ge    = (trial >= {1'b0, dm_in});
			lanes_n[i].rem = ge ? DW'(trial - {1'b0, dm_in}) : trial[DW-1:0];
			lanes_n[i].lq  = {lanes_in[i].lq[QW-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dm_s1    <= dm_in;
			lanes_s1 <= lanes_n;
		end
	end

endmodule

### rtl/core/affine_2x3_inverse_unit.sv
// ----------------------------------------------------------------------------
// affine_2x3_inverse_unit
// inverse of a 2d affine matrix [a c e; b d f] in signed q16.16
// ----------------------------------------------------------------------------
// A new matrix can be taken in every cycle that the pipeline advances; each one
// passes through three front stages for the products, the exact 64-bit
// determinant and the operand setup, 32 restoring-division stages producing
// one quotient bit per stage for all six entries side by side, and one output
// register. The whole pipeline advances together whenever the output register
// is empty or being taken, so in_ready follows out_ready and a stall holds
// every stage in place. Entries are numerator over determinant truncated
// toward zero; a quotient outside the q16.16 range saturates and raises
// overflow. A zero determinant gives all-zero entries with singular set.
// ----------------------------------------------------------------------------
module affine_2x3_inverse_unit
	import aff_inv_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] in_a,
	input  logic signed [31:0] in_b,
	input  logic signed [31:0] in_c,
	input  logic signed [31:0] in_d,
	input  logic signed [31:0] in_e,
	input  logic signed [31:0] in_f,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] out_a,
	output logic signed [31:0] out_b,
	output logic signed [31:0] out_c,
	output logic signed [31:0] out_d,
	output logic signed [31:0] out_e,
	output logic signed [31:0] out_f,
	output logic               singular,
	output logic               overflow
);

	// global advance: output slot free or being drained
	logic en;

	// stage chain between the front end and the output register
	ctl_t                  ctl_w   [NUM_STEPS+1];
	logic [DW-1:0]         dm_w    [NUM_STEPS+1];
	lane_t [NUM_LANES-1:0] lanes_w [NUM_STEPS+1];

	// final saturation and sign
	logic [QW-1:0] res   [NUM_LANES];
	logic          sat   [NUM_LANES];
	logic [QW-1:0] limit;
	logic [QW-1:0] mag;
	logic          any_sat;

	// output register
	logic          out_valid_q;
	logic [QW-1:0] res_q [NUM_LANES];
	logic          singular_q;
	logic          overflow_q;

	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	aff_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_valid),
		.in_a     (in_a),
		.in_b     (in_b),
		.in_c     (in_c),
		.in_d     (in_d),
		.in_e     (in_e),
		.in_f     (in_f),
		.ctl_s3   (ctl_w[0]),
		.dm_s3    (dm_w[0]),
		.lanes_s3 (lanes_w[0])
	);

	// one quotient bit per stage, most significant first
	for (genvar s = 0; s < NUM_STEPS; s++) begin : g_step
		aff_div_step u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.ctl_in   (ctl_w[s]),
			.dm_in    (dm_w[s]),
			.lanes_in (lanes_w[s]),
			.ctl_s1   (ctl_w[s+1]),
			.dm_s1    (dm_w[s+1]),
			.lanes_s1 (lanes_w[s+1])
		);
	end

	// saturate to the signed range, apply sign, zero everything when singular
	always_comb begin
		limit   = '0;
		mag     = '0;
		any_sat = 1'b0;
		for (int i = 0; i < NUM_LANES; i++) begin
			limit  = lanes_w[NUM_STEPS][i].neg ? NEG_LIMIT : POS_LIMIT;
			sat[i] = lanes_w[NUM_STEPS][i].ovf || (lanes_w[NUM_STEPS][i].lq > limit);
			mag    = sat[i] ? limit : lanes_w[NUM_STEPS][i].lq;
			res[i] = lanes_w[NUM_STEPS][i].neg ? (~mag + 32'd1) : mag;
			if (ctl_w[NUM_STEPS].singular) begin
				res[i] = '0;
				sat[i] = 1'b0;
			end
			any_sat = any_sat | sat[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= ctl_w[NUM_STEPS].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NUM_LANES; i++) begin
				res_q[i] <= res[i];
			end
			singular_q <= ctl_w[NUM_STEPS].singular;
			overflow_q <= any_sat;
		end
	end

	assign out_valid = out_valid_q;
	assign out_a     = res_q[LANE_A];
	assign out_b     = res_q[LANE_B];
	assign out_c     = res_q[LANE_C];
	assign out_d     = res_q[LANE_D];
	assign out_e     = res_q[LANE_E];
	assign out_f     = res_q[LANE_F];
	assign singular  = singular_q;
	assign overflow  = overflow_q;

	// a singular result carries zero entries and no overflow
	a_singular_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && singular |-> out_a == 0 && out_b == 0 && out_c == 0 &&
		out_d == 0 && out_e == 0 && out_f == 0 && !overflow)
		else $error("singular result with nonzero fields");

	// a held result blocks new transfers
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while output stalled");

	// a stall freezes the divider entry stage and the last division stage
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(ctl_w[0]) && $stable(ctl_w[NUM_STEPS]))
		else $error("pipeline moved during stall");

endmodule
